@@ rtl/facr_pkg.sv @@
// Shared types, constants and helpers for the fully associative cache tag store.
// Used by fully_assoc_cache_replacement; no other dependencies.
package facr_pkg;

  localparam int LINES_DEF      = 16;
  localparam int BLOCK_BITS_DEF = 16;
  localparam int IN_BLOCK_W     = 16;
  localparam int OUT_LINE_W     = 4;
  localparam int CNT_W          = 16;
  localparam int LFSR_W         = 16;
  localparam int POLICY_W       = 2;
  localparam int LIU_W          = 5;
  localparam int CFG_W          = 5;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LIU_W-1:0]  LIU_RESET = 5'd16;

  typedef enum logic [POLICY_W-1:0] {
    POL_RANDOM = 2'd0,
    POL_FIFO   = 2'd1,
    POL_LFU    = 2'd2,
    POL_LRU    = 2'd3
  } policy_t;

  typedef enum logic {
    CFG_POLICY = 1'b0,
    CFG_LINES  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DEC,
    S_MOD,
    S_GET,
    S_GETW,
    S_UPD,
    S_DONE
  } state_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
    logic b;
    b = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {b, l[LFSR_W-1:1]};
  endfunction

endpackage

@@ rtl/fully_assoc_cache_replacement.sv @@
// Top level of the fully associative cache tag store with selectable replacement.
// Depends on facr_pkg for types, constants and the LFSR step.
//
// One word in, one word out per access. An access scans the tag memory over the
// lines in use, takes a decision, fetches the chosen line, rewrites ages and counts
// in a second pass over the lines in use, and posts the result; a random replacement
// adds a bit-serial LFSR modulo step before the fetch. The next word is accepted
// only after the result is posted, so accesses do not overlap. The tag memory, with
// one read and one write per cycle, sets the pace of both passes.
// A new word is taken as soon as the previous one sits in the output register.
module fully_assoc_cache_replacement #(
  parameter int LINES      = facr_pkg::LINES_DEF,
  parameter int BLOCK_BITS = facr_pkg::BLOCK_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [facr_pkg::IN_BLOCK_W-1:0]  in_block,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [facr_pkg::OUT_LINE_W-1:0]  out_line,
  output logic                             out_evicted,
  output logic [facr_pkg::IN_BLOCK_W-1:0]  out_evicted_block,
  input  logic                             cfg_we,
  input  facr_pkg::cfg_idx_t               cfg_idx,
  input  logic [facr_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int IW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int NW = $clog2(LINES + 1);
  localparam int MW = $clog2(facr_pkg::LFSR_W + 1);
  localparam logic [IW-1:0] RMAX = IW'(LINES - 1);
  localparam logic [facr_pkg::CNT_W-1:0] CMAX = '1;

  typedef struct packed {
    logic [BLOCK_BITS-1:0]      blk;
    logic [facr_pkg::CNT_W-1:0] cnt;
    logic [IW-1:0]              rank;
  } entry_t;

  entry_t mem [LINES];
  entry_t rd_data_r;
  entry_t old_r;
  entry_t wd;
  logic   we;
  logic   rd_en;
  logic [IW-1:0] rd_addr;

  facr_pkg::state_t  state_r, state_nxt;
  facr_pkg::policy_t policy_r;
  logic [facr_pkg::LIU_W-1:0] liu_r;
  logic [LINES-1:0]           valid_r;
  logic [facr_pkg::LFSR_W-1:0] lfsr_r, q_r;
  logic [BLOCK_BITS-1:0]      blk_r;
  logic [NW-1:0]              n_r, scan_r, rem_r;
  logic [NW:0]                rem_tmp;
  logic [MW-1:0]              mcnt_r;
  logic                       rd_vld_r;
  logic [IW-1:0]              rd_idx_r;
  logic                       hit_f_r, emp_f_r;
  logic [IW-1:0]              hit_idx_r, emp_idx_r, lfu_idx_r, rk_idx_r, t_r;
  logic [facr_pkg::CNT_W-1:0] lfu_cnt_r;
  logic [BLOCK_BITS-1:0]      lfu_blk_r;
  logic [IW-1:0]              rk_max_r;
  logic                       out_valid_r, out_hit_r, out_ev_r;
  logic [facr_pkg::OUT_LINE_W-1:0] out_line_r;
  logic [facr_pkg::IN_BLOCK_W-1:0] out_evb_r;

  logic [NW-1:0]         n_in;
  logic [BLOCK_BITS-1:0] blk_in;
  logic                  promote, was_valid, scan_done;

  always_comb begin
    if (liu_r == '0) begin
      n_in = NW'(1);
    end else if ({1'b0, liu_r} > (facr_pkg::LIU_W + 1)'(LINES)) begin
      n_in = NW'(LINES);
    end else begin
      n_in = NW'(liu_r);
    end
  end

  assign blk_in    = BLOCK_BITS'({{BLOCK_BITS{1'b0}}, in_block});
  assign promote   = !hit_f_r || (policy_r == facr_pkg::POL_LRU);
  assign was_valid = hit_f_r || !emp_f_r;
  assign scan_done = (scan_r == n_r) && !rd_vld_r;
  assign rem_tmp   = {rem_r, q_r[facr_pkg::LFSR_W-1]};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      facr_pkg::S_IDLE: if (in_valid) state_nxt = facr_pkg::S_SCAN;
      facr_pkg::S_SCAN: if (scan_done) state_nxt = facr_pkg::S_DEC;
      facr_pkg::S_DEC: begin
        if (!hit_f_r && !emp_f_r && policy_r == facr_pkg::POL_RANDOM) begin
          state_nxt = facr_pkg::S_MOD;
        end else begin
          state_nxt = facr_pkg::S_GET;
        end
      end
      facr_pkg::S_MOD: if (mcnt_r == MW'(facr_pkg::LFSR_W - 1)) state_nxt = facr_pkg::S_GET;
      facr_pkg::S_GET:  state_nxt = facr_pkg::S_GETW;
      facr_pkg::S_GETW: state_nxt = facr_pkg::S_UPD;
      facr_pkg::S_UPD:  if (scan_done) state_nxt = facr_pkg::S_DONE;
      facr_pkg::S_DONE: if (!out_valid_r || !out_stall) state_nxt = facr_pkg::S_IDLE;
      default: state_nxt = facr_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = scan_r[IW-1:0];
    unique case (state_r)
      facr_pkg::S_IDLE: in_stall = 1'b0;
      facr_pkg::S_SCAN,
      facr_pkg::S_UPD:  rd_en = (scan_r != n_r);
      facr_pkg::S_GET: begin
        rd_en   = 1'b1;
        rd_addr = t_r;
      end
      default: rd_en = 1'b0;
    endcase
  end

  // write-back of the line read last cycle
  always_comb begin
    we = 1'b0;
    wd = rd_data_r;
    if (state_r == facr_pkg::S_UPD && rd_vld_r) begin
      if (rd_idx_r == t_r) begin
        we = 1'b1;
        if (hit_f_r) begin
          wd.cnt = (rd_data_r.cnt == CMAX) ? CMAX : rd_data_r.cnt + 1'b1;
        end else begin
          wd.blk = blk_r;
          wd.cnt = facr_pkg::CNT_W'(1);
        end
        if (promote) wd.rank = '0;
      end else if (valid_r[rd_idx_r] && promote &&
                   (!was_valid || rd_data_r.rank < old_r.rank) &&
                   rd_data_r.rank != RMAX) begin
        we = 1'b1;
        wd.rank = rd_data_r.rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
    if (we) mem[rd_idx_r] <= wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= facr_pkg::S_IDLE;
      policy_r    <= facr_pkg::POL_RANDOM;
      liu_r       <= facr_pkg::LIU_RESET;
      valid_r     <= '0;
      lfsr_r      <= facr_pkg::LFSR_SEED;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en && state_r != facr_pkg::S_GET;
      if (cfg_we) begin
        unique case (cfg_idx)
          facr_pkg::CFG_POLICY: policy_r <= facr_pkg::policy_t'(cfg_wdata[facr_pkg::POLICY_W-1:0]);
          facr_pkg::CFG_LINES:  liu_r    <= cfg_wdata[facr_pkg::LIU_W-1:0];
        endcase
      end
      if (we && rd_idx_r == t_r) valid_r[t_r] <= 1'b1;
      if (state_r == facr_pkg::S_DEC && state_nxt == facr_pkg::S_MOD) begin
        lfsr_r <= facr_pkg::lfsr_step(lfsr_r);
      end
      out_valid_r <= (state_r == facr_pkg::S_DONE && state_nxt == facr_pkg::S_IDLE) ||
                     (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_idx_r <= rd_addr;
    unique case (state_r)
      facr_pkg::S_IDLE: begin
        blk_r   <= blk_in;
        n_r     <= n_in;
        scan_r  <= '0;
        hit_f_r <= 1'b0;
        emp_f_r <= 1'b0;
      end
      facr_pkg::S_SCAN: begin
        if (rd_en) scan_r <= scan_r + 1'b1;
        if (scan_done) scan_r <= '0;
        if (rd_vld_r) begin
          if (!hit_f_r && valid_r[rd_idx_r] && rd_data_r.blk == blk_r) begin
            hit_f_r   <= 1'b1;
            hit_idx_r <= rd_idx_r;
          end
          if (!emp_f_r && !valid_r[rd_idx_r]) begin
            emp_f_r   <= 1'b1;
            emp_idx_r <= rd_idx_r;
          end
          if (rd_idx_r == '0 || rd_data_r.cnt < lfu_cnt_r ||
              (rd_data_r.cnt == lfu_cnt_r && rd_data_r.blk < lfu_blk_r)) begin
            lfu_idx_r <= rd_idx_r;
            lfu_cnt_r <= rd_data_r.cnt;
            lfu_blk_r <= rd_data_r.blk;
          end
          if (rd_idx_r == '0 || rd_data_r.rank > rk_max_r) begin
            rk_idx_r <= rd_idx_r;
            rk_max_r <= rd_data_r.rank;
          end
        end
      end
      facr_pkg::S_DEC: begin
        q_r    <= facr_pkg::lfsr_step(lfsr_r);
        rem_r  <= '0;
        mcnt_r <= '0;
        priority if (hit_f_r)                        t_r <= hit_idx_r;
        else if (emp_f_r)                            t_r <= emp_idx_r;
        else if (policy_r == facr_pkg::POL_LFU)      t_r <= lfu_idx_r;
        else                                         t_r <= rk_idx_r;
      end
      facr_pkg::S_MOD: begin
        q_r    <= q_r << 1;
        mcnt_r <= mcnt_r + 1'b1;
        if (rem_tmp >= {1'b0, n_r}) begin
          rem_r <= NW'(rem_tmp - {1'b0, n_r});
          t_r   <= IW'(rem_tmp - {1'b0, n_r});
        end else begin
          rem_r <= NW'(rem_tmp);
          t_r   <= IW'(rem_tmp);
        end
      end
      facr_pkg::S_GETW: old_r <= rd_data_r;
      facr_pkg::S_UPD: begin
        if (rd_en) scan_r <= scan_r + 1'b1;
      end
      facr_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_hit_r  <= hit_f_r;
          out_line_r <= facr_pkg::OUT_LINE_W'({{facr_pkg::OUT_LINE_W{1'b0}}, t_r});
          out_ev_r   <= !was_valid ? 1'b0 : !hit_f_r;
          out_evb_r  <= (!hit_f_r && !emp_f_r) ?
                        facr_pkg::IN_BLOCK_W'({{facr_pkg::IN_BLOCK_W{1'b0}}, old_r.blk}) : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_line          = out_line_r;
  assign out_evicted       = out_ev_r;
  assign out_evicted_block = out_evb_r;

`ifndef SYNTH
  a_ev_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r |-> !out_hit_r)
    else $error("eviction reported on a hit");

  a_valid_grow: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) >= $past($countones(valid_r)))
    else $error("valid line lost");

  a_mod_only_random: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == facr_pkg::S_MOD |-> !hit_f_r && !emp_f_r && policy_r == facr_pkg::POL_RANDOM)
    else $error("random victim search without random replacement");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> state_r == facr_pkg::S_UPD)
    else $error("tag write outside update pass");
`endif

endmodule
